/* hdl/tse_pkg.sv */
// shared types and constants of the series evaluator
`default_nettype none
package tse_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int FRAC_BITS_DEF = 28;

  localparam int X_W     = 32;
  localparam int MAG_W   = 47;
  localparam int SUM_W   = 54;
  localparam int OUT_W   = 48;
  localparam int N_W     = 6;
  localparam int CNT_W   = 5;
  localparam int DIV_W   = 12;
  localparam int RECIP_W = 49;
  localparam int MM_W    = 48;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SIN  = 2'd0,
    OP_COS  = 2'd1,
    OP_EXP  = 2'd2,
    OP_LN1P = 2'd3
  } op_e;

  // everything an item carries from one term unit to the next
  typedef struct packed {
    logic                    valid;
    op_e                     op;
    logic                    xneg;
    logic [X_W-1:0]          xmag;
    logic [MAG_W-1:0]        x2;
    logic [N_W-1:0]          n;
    logic [MAG_W-1:0]        mag;
    logic                    neg;
    logic signed [SUM_W-1:0] sum;
    logic                    sat;
  } ctx_t;

endpackage
`default_nettype wire

/* hdl/tse_mul.sv */
// two-stage multiply, round and saturate of a magnitude by x or x squared
`default_nettype none
module tse_mul #(
  parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [tse_pkg::MAG_W-1:0] a_i,
  input  wire logic [tse_pkg::MAG_W-1:0] b_i,
  output logic      [tse_pkg::MAG_W-1:0] prod_o,
  output logic                          sat_o
);
  import tse_pkg::*;

  localparam int B_W  = (63 - FRAC_BITS > X_W) ? 63 - FRAC_BITS : X_W;
  localparam int LO_W = 24;
  localparam int HI_W = MAG_W - LO_W;
  localparam int P_W  = MAG_W + B_W + 1;
  localparam logic [P_W-1:0] HALF = {{(P_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic [LO_W+B_W-1:0] pl_q;
  logic [HI_W+B_W-1:0] ph_q;
  logic [P_W-1:0]      full, rnd;
  logic                sat_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q <= a_i[LO_W-1:0] * b_i[B_W-1:0];
      ph_q <= a_i[MAG_W-1:LO_W] * b_i[B_W-1:0];
    end
  end

  always_comb begin
    full  = P_W'(pl_q) + P_W'({ph_q, {LO_W{1'b0}}}) + HALF;
    rnd   = full >> FRAC_BITS;
    sat_d = |rnd[P_W-1:MAG_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= sat_d ? MAG_MAX : rnd[MAG_W-1:0];
      sat_o  <= sat_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/tse_div.sv */
// four-stage rounded division by a small constant through its reciprocal
`default_nettype none
module tse_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [tse_pkg::MAG_W-1:0]   m_i,
  input  wire logic [tse_pkg::DIV_W-1:0]   d_i,
  input  wire logic [tse_pkg::DIV_W-1:0]   hd_i,
  input  wire logic [tse_pkg::RECIP_W-1:0] recip_i,
  output logic      [tse_pkg::MAG_W-1:0]   q_o
);
  import tse_pkg::*;

  localparam int QD_W = RECIP_W + DIV_W;
  localparam int T_W  = MM_W + RECIP_W;

  logic [MM_W-1:0]    mm1_q, mm2_q, mm3_q, mm4_q;
  logic [DIV_W-1:0]   d1_q, d2_q, d3_q, d4_q;
  logic [RECIP_W-1:0] rc1_q;
  logic [48:0]        pll_q, phl_q;
  logic [47:0]        plh_q, phh_q;
  logic [RECIP_W-1:0] q03_q, q04_q;
  logic [QD_W-1:0]    qd4_q;
  logic [T_W-1:0]     tot;
  logic [QD_W-1:0]    rem;
  logic [RECIP_W-1:0] q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mm1_q <= MM_W'(m_i) + MM_W'(hd_i);
      d1_q  <= d_i;
      rc1_q <= recip_i;
      // partial products of the reciprocal multiply
      pll_q <= mm1_q[23:0]  * rc1_q[24:0];
      plh_q <= mm1_q[23:0]  * rc1_q[48:25];
      phl_q <= mm1_q[47:24] * rc1_q[24:0];
      phh_q <= mm1_q[47:24] * rc1_q[48:25];
      mm2_q <= mm1_q;
      d2_q  <= d1_q;
      q03_q <= tot[T_W-1:MM_W];
      mm3_q <= mm2_q;
      d3_q  <= d2_q;
      qd4_q <= q03_q * d3_q;
      q04_q <= q03_q;
      mm4_q <= mm3_q;
      d4_q  <= d3_q;
    end
  end

  always_comb begin
    tot = T_W'(pll_q) + (T_W'(plh_q) << 25) + (T_W'(phl_q) << 24) + (T_W'(phh_q) << 49);
    // estimate is low by at most one
    rem = QD_W'(mm4_q) - qd4_q;
    q   = (rem >= QD_W'(d4_q)) ? q04_q + RECIP_W'(1) : q04_q;
    q_o = q[MAG_W-1:0];
  end

endmodule
`default_nettype wire

/* hdl/tse_term.sv */
// one term unit: next magnitude, its division and the running sum
`default_nettype none
module tse_term #(
  parameter int K         = 1,
  parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire tse_pkg::ctx_t ctx_i,
  output tse_pkg::ctx_t      ctx_o
);
  import tse_pkg::*;

  localparam int DSIN = (2 * K) * (2 * K + 1);
  localparam int DCOS = (2 * K - 1) * (2 * K);
  localparam int DEXP = K;
  localparam int DLN  = K + 1;
  localparam logic [63:0] ONE48 = 64'd1 << 48;
  localparam logic [63:0] RSIN  = ONE48 / DSIN;
  localparam logic [63:0] RCOS  = ONE48 / DCOS;
  localparam logic [63:0] REXP  = ONE48 / DEXP;
  localparam logic [63:0] RLN   = ONE48 / DLN;
  localparam logic [N_W-1:0] KN = N_W'(K);

  ctx_t               c_q [6];
  ctx_t               c2_d, o_d;
  logic [MAG_W-1:0]   b_op, prod, q;
  logic               psat;
  logic [DIV_W-1:0]   dsel, hsel;
  logic [RECIP_W-1:0] rsel;
  logic               tneg;
  logic               active;

  always_comb begin
    b_op = ((ctx_i.op == OP_SIN) || (ctx_i.op == OP_COS)) ? ctx_i.x2 : MAG_W'(ctx_i.xmag);
  end

  tse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .a_i    (ctx_i.mag),
    .b_i    (b_op),
    .prod_o (prod),
    .sat_o  (psat)
  );

  always_comb begin
    unique case (c_q[1].op)
      OP_SIN: begin
        dsel = DIV_W'(DSIN);
        rsel = RSIN[RECIP_W-1:0];
      end
      OP_COS: begin
        dsel = DIV_W'(DCOS);
        rsel = RCOS[RECIP_W-1:0];
      end
      OP_EXP: begin
        dsel = DIV_W'(DEXP);
        rsel = REXP[RECIP_W-1:0];
      end
      OP_LN1P: begin
        dsel = DIV_W'(DLN);
        rsel = RLN[RECIP_W-1:0];
      end
      default: begin
        dsel = DIV_W'(DEXP);
        rsel = REXP[RECIP_W-1:0];
      end
    endcase
    hsel = dsel >> 1;
    // the product replaces the magnitude; only a summed term may flag it
    c2_d     = c_q[1];
    c2_d.mag = prod;
    c2_d.sat = c_q[1].sat | ((KN < c_q[1].n) & psat);
  end

  tse_div u_div (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .m_i     (prod),
    .d_i     (dsel),
    .hd_i    (hsel),
    .recip_i (rsel),
    .q_o     (q)
  );

  always_comb begin
    o_d    = c_q[5];
    active = KN < c_q[5].n;
    // ln(1+x) keeps the plain power and divides only the summed term
    if (c_q[5].op != OP_LN1P) begin
      o_d.mag = q;
    end
    if ((c_q[5].op == OP_SIN) || (c_q[5].op == OP_COS)) begin
      o_d.neg = ~c_q[5].neg;
    end else begin
      o_d.neg = c_q[5].neg ^ c_q[5].xneg;
    end
    tneg = (c_q[5].op == OP_LN1P) ? (o_d.neg ^ KN[0]) : o_d.neg;
    if (active) begin
      o_d.sum = tneg ? c_q[5].sum - SUM_W'(q) : c_q[5].sum + SUM_W'(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) c_q[i] <= '0;
      ctx_o <= '0;
    end else if (en_i) begin
      c_q[0] <= ctx_i;
      c_q[1] <= c_q[0];
      c_q[2] <= c2_d;
      c_q[3] <= c_q[2];
      c_q[4] <= c_q[3];
      c_q[5] <= c_q[4];
      ctx_o  <= o_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/taylor_series_evaluator.sv */
// top level of the truncated maclaurin series evaluator
//
//  channel  direction  ports
//  in       input      in_valid_i / in_ready_o : operation_i, x_value_i, term_count_i
//  out      output     out_valid_o / out_ready_i : series_sum_o, overflowed_o
//
// one item enters per cycle unless a held result is waiting to be taken
// each term unit holds its own two-stage multiplier and four-stage divider
// the whole pipeline stalls as one while a held result is not taken
// reset clears all valid bits; no clearing pass is needed
`default_nettype none
module taylor_series_evaluator #(
  parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = tse_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic signed [tse_pkg::X_W-1:0] x_value_i,
  input  wire logic [tse_pkg::CNT_W-1:0]     term_count_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [tse_pkg::OUT_W-1:0]   series_sum_o,
  output logic                               overflowed_o
);
  import tse_pkg::*;

  localparam logic [2*X_W-1:0] HALF = {{(2*X_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic [MAG_W-1:0] ONE  = {{(MAG_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SMAX = SUM_W'(MAG_MAX);
  localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

  logic              en;
  ctx_t              e0_q, e0_d, e1_q, e1_d;
  ctx_t              chain [MAX_TERMS];
  logic [N_W-1:0]    n_in;
  logic [2*X_W-1:0]  sq;
  logic [MAG_W-1:0]  mag0;
  logic              neg0;
  logic signed [OUT_W-1:0] sum_d;
  logic              sat_d;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    n_in = ({1'b0, term_count_i} > N_W'(MAX_TERMS)) ? N_W'(MAX_TERMS) : {1'b0, term_count_i};
    e0_d       = '0;
    e0_d.valid = in_valid_i;
    e0_d.op    = op_e'(operation_i);
    e0_d.xneg  = x_value_i[X_W-1];
    e0_d.xmag  = x_value_i[X_W-1] ? -x_value_i : x_value_i;
    e0_d.n     = n_in;
  end

  // x squared and the first term
  always_comb begin
    sq   = (e0_q.xmag * e0_q.xmag + HALF) >> FRAC_BITS;
    e1_d = e0_q;
    e1_d.x2 = sq[MAG_W-1:0];
    if ((e0_q.op == OP_SIN) || (e0_q.op == OP_LN1P)) begin
      mag0 = MAG_W'(e0_q.xmag);
      neg0 = e0_q.xneg;
    end else begin
      mag0 = ONE;
      neg0 = 1'b0;
    end
    e1_d.mag = mag0;
    e1_d.neg = neg0;
    e1_d.sat = 1'b0;
    if (e0_q.n == '0) begin
      e1_d.sum = '0;
    end else begin
      e1_d.sum = neg0 ? -SUM_W'(mag0) : SUM_W'(mag0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_q <= '0;
      e1_q <= '0;
    end else if (en) begin
      e0_q <= e0_d;
      e1_q <= e1_d;
    end
  end

  assign chain[0] = e1_q;

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
    tse_term #(.K(k), .FRAC_BITS(FRAC_BITS)) u_term (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctx_i  (chain[k-1]),
      .ctx_o  (chain[k])
    );
  end

  always_comb begin
    sat_d = chain[MAX_TERMS-1].sat;
    if (chain[MAX_TERMS-1].sum > SMAX) begin
      sum_d = SMAX[OUT_W-1:0];
      sat_d = 1'b1;
    end else if (chain[MAX_TERMS-1].sum < SMIN) begin
      sum_d = SMIN[OUT_W-1:0];
      sat_d = 1'b1;
    end else begin
      sum_d = chain[MAX_TERMS-1].sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= chain[MAX_TERMS-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      series_sum_o <= sum_d;
      overflowed_o <= sat_d;
    end
  end

endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for the truncated maclaurin series evaluator
`timescale 1ns / 1ps
module tb;
  import tse_pkg::*;

  localparam int LATENCY = 3 + 7 * (MAX_TERMS_DEF - 1);

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = '0;
  logic signed [31:0] x_value_i = '0;
  logic [4:0]         term_count_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [47:0] series_sum_o;
  logic               overflowed_o;

  typedef struct {
    logic signed [47:0] sum;
    logic               ovf;
  } series_res_t;

  series_res_t sums_pending[$];
  int          n_fail = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          recv_hold = 0;

  taylor_series_evaluator DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // magnitude product with rounding, clamped to 47 bits
  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, ref bit sat);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (FRAC_BITS_DEF - 1));
    p = p >> FRAC_BITS_DEF;
    if (p > 128'(MAG_MAX)) begin
      sat = 1'b1;
      return 64'(MAG_MAX);
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] div_rnd(logic [63:0] m, logic [63:0] d);
    return (m + d / 2) / d;
  endfunction

  function automatic series_res_t series_eval(op_e op, logic [31:0] xr, logic [4:0] cnt);
    series_res_t r;
    bit          sat, dummy;
    bit          xneg, neg, tneg;
    logic [31:0] xm32;
    logic [63:0] xmag, x2, mag, tmag, kk;
    longint      acc;
    int          n;
    xneg = xr[31];
    xm32 = xneg ? ((~xr) + 32'd1) : xr;
    xmag = {32'd0, xm32};
    dummy = 1'b0;
    x2 = fx_mul(xmag, xmag, dummy);
    sat = 1'b0;
    acc = 0;
    n = (cnt > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(cnt);
    if (op == OP_SIN || op == OP_LN1P) begin
      mag = xmag;
      neg = xneg;
    end else begin
      mag = 64'd1 << FRAC_BITS_DEF;
      neg = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      kk = 64'(k);
      if (k > 0) begin
        case (op)
          OP_SIN: begin
            mag = div_rnd(fx_mul(mag, x2, sat), (2 * kk) * (2 * kk + 1));
            neg = !neg;
          end
          OP_COS: begin
            mag = div_rnd(fx_mul(mag, x2, sat), (2 * kk - 1) * (2 * kk));
            neg = !neg;
          end
          OP_EXP: begin
            mag = div_rnd(fx_mul(mag, xmag, sat), kk);
            neg = neg ^ xneg;
          end
          default: begin
            mag = fx_mul(mag, xmag, sat);
            neg = neg ^ xneg;
          end
        endcase
      end
      if (op == OP_LN1P) begin
        tmag = div_rnd(mag, kk + 1);
        tneg = neg ^ kk[0];
      end else begin
        tmag = mag;
        tneg = neg;
      end
      if (tneg) acc -= longint'(tmag);
      else acc += longint'(tmag);
    end
    if (acc > longint'(MAG_MAX)) begin
      acc = longint'(MAG_MAX);
      sat = 1'b1;
    end else if (acc < -longint'(MAG_MAX) - 1) begin
      acc = -longint'(MAG_MAX) - 1;
      sat = 1'b1;
    end
    r.sum = acc[47:0];
    r.ovf = sat;
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(op_e op, logic [31:0] x, logic [4:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    x_value_i <= x;
    term_count_i <= cnt;
    sums_pending.push_back(series_eval(op, x, cnt));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stalls, with an optional long hold-off counted in cycles
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    series_res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sums_pending.size() == 0) begin
        $error("result with no item outstanding: sum %0d", series_sum_o);
        n_fail++;
      end else begin
        exp_r = sums_pending.pop_front();
        if (series_sum_o !== exp_r.sum) begin
          $error("series_sum expected %0d actual %0d", exp_r.sum, series_sum_o);
          n_fail++;
        end
        if (overflowed_o !== exp_r.ovf) begin
          $error("overflowed expected %0b actual %0b", exp_r.ovf, overflowed_o);
          n_fail++;
        end
      end
    end
  end

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sums_pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_x();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2 ** 29)) - 2 ** 28);
      2: return 32'($signed($urandom_range(2 ** 30)) - 2 ** 29);
      default: return {{4{1'($urandom_range(1))}}, 28'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] xs[6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1000_0000,
                           32'hf000_0000, 32'hffff_ffff};
    for (int o = 0; o < 4; o++) begin
      send_item(op_e'(o), 32'h1000_0000, 5'd0);
      send_item(op_e'(o), 32'h0800_0000, 5'd31);
      foreach (xs[i]) send_item(op_e'(o), xs[i], (i % 2) ? 5'd16 : 5'd17);
    end
    drain_results();
  endtask

  task automatic test_random(int items, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (items) begin
      send_item(op_e'($urandom_range(3)), rand_x(),
                ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(16)));
    end
    drain_results();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // hold the output long enough for the pipeline to fill and stall its input
  task automatic test_backpressure();
    recv_hold = 4 * LATENCY;
    test_random(3 * LATENCY, 0, 0);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(350, 0, 0);
    test_random(350, 63, 0);
    test_random(350, 0, 63);
    test_random(350, 14, 14);
    test_backpressure();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (n_fail == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
